// ===== sv/csl_pkg.sv =====
// Package for the C subset lexer: token record, kind and mode codes, sizes.
package csl_pkg;

  localparam int POS_BITS      = 16;
  localparam int START_BITS    = 16;
  localparam int LEN_BITS      = 16;
  localparam int VALUE_BITS    = 63;
  localparam int PREFIX_DEPTH  = 6;
  localparam int PREFIX_IDX_BITS = $clog2(PREFIX_DEPTH);
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam logic [VALUE_BITS-1:0] VALUE_MAX  = {VALUE_BITS{1'b1}};
  localparam logic [VALUE_BITS-1:0] NUM_SAT_Q  = VALUE_MAX / 10;
  localparam logic [LEN_BITS-1:0]   LEN_MAX    = {LEN_BITS{1'b1}};

  localparam logic [3:0] K_PUNCT  = 4'd0;
  localparam logic [3:0] K_IDENT  = 4'd1;
  localparam logic [3:0] K_NUM    = 4'd2;
  localparam logic [3:0] K_IF     = 4'd3;
  localparam logic [3:0] K_ELSE   = 4'd4;
  localparam logic [3:0] K_WHILE  = 4'd5;
  localparam logic [3:0] K_FOR    = 4'd6;
  localparam logic [3:0] K_RETURN = 4'd7;
  localparam logic [3:0] K_SIZEOF = 4'd8;
  localparam logic [3:0] K_I32    = 4'd9;
  localparam logic [3:0] K_I64    = 4'd10;
  localparam logic [3:0] K_EOF    = 4'd11;
  localparam logic [3:0] K_ERROR  = 4'd12;

  localparam logic [3:0] M_IDLE  = 4'd0;
  localparam logic [3:0] M_IDENT = 4'd1;
  localparam logic [3:0] M_NUM   = 4'd2;
  localparam logic [3:0] M_SLASH = 4'd3;
  localparam logic [3:0] M_LINE  = 4'd4;
  localparam logic [3:0] M_BLOCK = 4'd5;
  localparam logic [3:0] M_BSTAR = 4'd6;
  localparam logic [3:0] M_BANG  = 4'd7;
  localparam logic [3:0] M_CMP   = 4'd8;

  typedef struct packed {
    logic [3:0]            kind;
    logic [START_BITS-1:0] start_res;
    logic [LEN_BITS-1:0]   length;
    logic [VALUE_BITS-1:0] value;
    logic [7:0]            op_first;
    logic [7:0]            op_second;
    logic                  last;
  } tok_t;

endpackage

// ===== sv/csl_core.sv =====
// Lexer state and the per-character logic that forms up to two tokens.
module csl_core import csl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  logic [7:0] ch,
  output tok_t       res0,
  output tok_t       res1,
  output logic [1:0] res_n
);

  logic [3:0]            mode, mode_next;
  logic [POS_BITS-1:0]   position, position_next;
  logic [POS_BITS-1:0]   token_start, token_start_next;
  logic [LEN_BITS-1:0]   token_length, token_length_next;
  logic [7:0]            prefix [PREFIX_DEPTH];
  logic [7:0]            prefix_next [PREFIX_DEPTH];
  logic [VALUE_BITS-1:0] number_value, number_value_next;
  logic [7:0]            pending, pending_next;
  logic                  halted, halted_next;

  tok_t res_a, res_b;
  logic a_v, b_v, reuse, reset_all;
  logic [VALUE_BITS-1:0] digit;

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= "a" && c <= "z") || c == "_";
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_lower(c) || (c >= "A" && c <= "Z") || is_digit(c);
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return c == ";" || c == "(" || c == ")" || c == "," || c == "{" ||
           c == "}" || c == "-" || c == "+" || c == "*" || c == "&";
  endfunction

  function automatic tok_t make_tok(input logic [3:0] k, input logic [POS_BITS-1:0] s,
                                    input logic [LEN_BITS-1:0] l,
                                    input logic [VALUE_BITS-1:0] v,
                                    input logic [7:0] o1, input logic [7:0] o2);
    tok_t t;
    t.kind      = k;
    t.start_res = START_BITS'(s);
    t.length    = l;
    t.value     = v;
    t.op_first  = o1;
    t.op_second = o2;
    t.last      = 1'b0;
    return t;
  endfunction

  function automatic logic [3:0] kw_kind(input logic [7:0] p [PREFIX_DEPTH],
                                         input logic [LEN_BITS-1:0] l);
    logic [3:0] k;
    k = K_IDENT;
    if (l == LEN_BITS'(2) && p[0] == "i" && p[1] == "f") begin
      k = K_IF;
    end else if (l == LEN_BITS'(3)) begin
      if (p[0] == "f" && p[1] == "o" && p[2] == "r") k = K_FOR;
      else if (p[0] == "i" && p[1] == "6" && p[2] == "4") k = K_I64;
      else if (p[0] == "i" && p[1] == "3" && p[2] == "2") k = K_I32;
      else if (p[0] == "i" && p[1] == "n" && p[2] == "t") k = K_I32;
    end else if (l == LEN_BITS'(4)) begin
      if (p[0] == "e" && p[1] == "l" && p[2] == "s" && p[3] == "e") k = K_ELSE;
      else if (p[0] == "l" && p[1] == "o" && p[2] == "n" && p[3] == "g") k = K_I64;
    end else if (l == LEN_BITS'(5)) begin
      if (p[0] == "w" && p[1] == "h" && p[2] == "i" && p[3] == "l" && p[4] == "e")
        k = K_WHILE;
    end else if (l == LEN_BITS'(6)) begin
      if (p[0] == "r" && p[1] == "e" && p[2] == "t" && p[3] == "u" && p[4] == "r" &&
          p[5] == "n") k = K_RETURN;
      else if (p[0] == "s" && p[1] == "i" && p[2] == "z" && p[3] == "e" &&
               p[4] == "o" && p[5] == "f") k = K_SIZEOF;
    end
    return k;
  endfunction

  assign digit = VALUE_BITS'(ch[3:0]);

  always_comb begin
    mode_next         = mode;
    position_next     = position + POS_BITS'(1);
    token_start_next  = token_start;
    token_length_next = token_length;
    prefix_next       = prefix;
    number_value_next = number_value;
    pending_next      = pending;
    halted_next       = halted;
    res_a     = '0;
    res_b     = '0;
    a_v       = 1'b0;
    b_v       = 1'b0;
    reuse     = 1'b0;
    reset_all = 1'b0;

    if (halted) begin
      if (ch == 8'd0) begin
        res_b     = make_tok(K_EOF, position, LEN_BITS'(1), '0, 8'd0, 8'd0);
        b_v       = 1'b1;
        reset_all = 1'b1;
      end
    end else begin
      unique case (mode)
        M_IDENT: begin
          if (is_word(ch)) begin
            if (token_length < LEN_BITS'(PREFIX_DEPTH)) begin
              prefix_next[token_length[PREFIX_IDX_BITS-1:0]] = ch;
            end
            if (token_length != LEN_MAX) begin
              token_length_next = token_length + LEN_BITS'(1);
            end
          end else begin
            res_a = make_tok(kw_kind(prefix, token_length), token_start, token_length,
                             '0, 8'd0, 8'd0);
            a_v   = 1'b1;
            reuse = 1'b1;
          end
        end
        M_NUM: begin
          if (is_digit(ch)) begin
            if (number_value > NUM_SAT_Q ||
                (number_value == NUM_SAT_Q && ch[3:0] > 4'd7)) begin
              number_value_next = VALUE_MAX;
            end else begin
              number_value_next = (number_value << 3) + (number_value << 1) + digit;
            end
          end else begin
            res_a = make_tok(K_NUM, token_start, LEN_BITS'(1), number_value, 8'd0, 8'd0);
            a_v   = 1'b1;
            reuse = 1'b1;
          end
        end
        M_SLASH: begin
          if (ch == "/") begin
            mode_next = M_LINE;
          end else if (ch == "*") begin
            mode_next = M_BLOCK;
          end else begin
            res_a = make_tok(K_PUNCT, token_start, LEN_BITS'(1), '0, "/", 8'd0);
            a_v   = 1'b1;
            reuse = 1'b1;
          end
        end
        M_LINE: begin
          if (ch == "\n") mode_next = M_IDLE;
          else if (ch == 8'd0) reuse = 1'b1;
        end
        M_BLOCK, M_BSTAR: begin
          if (ch == 8'd0) reuse = 1'b1;
          else if (mode == M_BSTAR && ch == "/") mode_next = M_IDLE;
          else if (ch == "*") mode_next = M_BSTAR;
          else mode_next = M_BLOCK;
        end
        M_BANG: begin
          a_v = 1'b1;
          if (ch == 8'd0) begin
            res_a = make_tok(K_PUNCT, token_start, LEN_BITS'(1), '0, "!", 8'd0);
            reuse = 1'b1;
          end else begin
            res_a = make_tok(K_PUNCT, token_start, LEN_BITS'(2), '0, "!", ch);
          end
          mode_next = M_IDLE;
        end
        M_CMP: begin
          a_v = 1'b1;
          if (ch == "=") begin
            res_a = make_tok(K_PUNCT, token_start, LEN_BITS'(2), '0, pending, "=");
          end else begin
            res_a = make_tok(K_PUNCT, token_start, LEN_BITS'(1), '0, pending, 8'd0);
            reuse = 1'b1;
          end
          pending_next = 8'd0;
          mode_next    = M_IDLE;
        end
        default: begin
          reuse = 1'b1;
        end
      endcase

      if (reuse) begin
        mode_next = M_IDLE;
        if (ch == 8'd0) begin
          res_b     = make_tok(K_EOF, position, LEN_BITS'(1), '0, 8'd0, 8'd0);
          b_v       = 1'b1;
          reset_all = 1'b1;
        end else if (is_space(ch)) begin
          mode_next = M_IDLE;
        end else if (is_lower(ch)) begin
          for (int i = 0; i < PREFIX_DEPTH; i++) prefix_next[i] = 8'd0;
          prefix_next[0]    = ch;
          token_start_next  = position;
          token_length_next = LEN_BITS'(1);
          mode_next         = M_IDENT;
        end else if (ch == "/") begin
          token_start_next = position;
          mode_next        = M_SLASH;
        end else if (is_punct(ch)) begin
          res_b = make_tok(K_PUNCT, position, LEN_BITS'(1), '0, ch, 8'd0);
          b_v   = 1'b1;
        end else if (ch == "!") begin
          token_start_next = position;
          mode_next        = M_BANG;
        end else if (ch == "=" || ch == "<" || ch == ">") begin
          token_start_next = position;
          pending_next     = ch;
          mode_next        = M_CMP;
        end else if (is_digit(ch)) begin
          token_start_next  = position;
          number_value_next = digit;
          mode_next         = M_NUM;
        end else begin
          res_b       = make_tok(K_ERROR, position, LEN_BITS'(1), '0, 8'd0, 8'd0);
          b_v         = 1'b1;
          halted_next = 1'b1;
        end
      end
    end

    if (reset_all) begin
      mode_next         = M_IDLE;
      position_next     = '0;
      token_start_next  = '0;
      token_length_next = '0;
      for (int i = 0; i < PREFIX_DEPTH; i++) prefix_next[i] = 8'd0;
      number_value_next = '0;
      pending_next      = 8'd0;
      halted_next       = 1'b0;
    end
  end

  always_comb begin
    res0      = a_v ? res_a : res_b;
    res0.last = !(a_v && b_v);
    res1      = res_b;
    res1.last = 1'b1;
    res_n     = 2'(a_v) + 2'(b_v);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_IDLE;
      position     <= '0;
      token_start  <= '0;
      token_length <= '0;
      for (int i = 0; i < PREFIX_DEPTH; i++) prefix[i] <= 8'd0;
      number_value <= '0;
      pending      <= 8'd0;
      halted       <= 1'b0;
    end else if (go) begin
      mode         <= mode_next;
      position     <= position_next;
      token_start  <= token_start_next;
      token_length <= token_length_next;
      prefix       <= prefix_next;
      number_value <= number_value_next;
      pending      <= pending_next;
      halted       <= halted_next;
    end
  end

endmodule

// ===== sv/csl_out_queue.sv =====
// Shifting result queue that takes up to two tokens a cycle and hands out one.
module csl_out_queue import csl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  tok_t       res0,
  input  tok_t       res1,
  input  logic [1:0] push_n,
  output logic       room,
  output logic       head_valid,
  input  logic       head_stall,
  output tok_t       head
);

  tok_t q [QUEUE_DEPTH];
  tok_t q_next [QUEUE_DEPTH];
  logic [QUEUE_CNT_BITS-1:0] cnt, cnt_next, cap;
  logic pop;

  assign head_valid = cnt != '0;
  assign head       = q[0];
  assign pop        = head_valid && !head_stall;
  assign room       = cnt <= QUEUE_CNT_BITS'(QUEUE_DEPTH - 2);

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      q_next[i] = pop ? q[i+1] : q[i];
    end
    q_next[QUEUE_DEPTH-1] = q[QUEUE_DEPTH-1];
    cap = cnt - QUEUE_CNT_BITS'(pop);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (push_n != 2'd0 && QUEUE_CNT_BITS'(i) == cap) begin
        q_next[i] = res0;
      end
      if (push_n == 2'd2 && QUEUE_CNT_BITS'(i) == cap + QUEUE_CNT_BITS'(1)) begin
        q_next[i] = res1;
      end
    end
    cnt_next = cap + QUEUE_CNT_BITS'(push_n);
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

endmodule

// ===== sv/c_subset_lexer.sv =====
// Top level of the C subset lexer: input register, lexer core and result queue.
// The lexer takes one source character per cycle on the src channel and gives
// tokens on the tok channel, one per cycle while tok_stall is low. A character
// is held in an input register, goes through the lexer core once the result
// queue has room and produces zero, one or two tokens, which wait in a
// four-entry result queue; the first token is visible once it is in the queue.
// The sustained rate is one character per cycle as long as tokens are taken
// as fast as they come; a character is held back only while the result queue
// has fewer than two free entries. A zero character ends the text and yields
// an end-of-text token, after which offsets start again from zero.
module c_subset_lexer import csl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  src_valid,
  output logic                  src_stall,
  input  logic [7:0]            ch,
  output logic                  tok_valid,
  input  logic                  tok_stall,
  output logic [3:0]            kind,
  output logic [START_BITS-1:0] start_res,
  output logic [LEN_BITS-1:0]   length,
  output logic [VALUE_BITS-1:0] value,
  output logic [7:0]            op_first,
  output logic [7:0]            op_second,
  output logic                  last
);

  logic       ch_full;
  logic [7:0] ch_q;
  logic       room, go, take;
  tok_t       res0, res1, head;
  logic [1:0] res_n;

  assign go        = ch_full && room;
  assign src_stall = ch_full && !room;
  assign take      = src_valid && !src_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_full <= 1'b0;
    end else if (take) begin
      ch_full <= 1'b1;
    end else if (go) begin
      ch_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ch_q <= ch;
    end
  end

  csl_core u_core (
    .clk   (clk),
    .rst   (rst),
    .go    (go),
    .ch    (ch_q),
    .res0  (res0),
    .res1  (res1),
    .res_n (res_n)
  );

  csl_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .res0       (res0),
    .res1       (res1),
    .push_n     (go ? res_n : 2'd0),
    .room       (room),
    .head_valid (tok_valid),
    .head_stall (tok_stall),
    .head       (head)
  );

  assign kind      = head.kind;
  assign start_res = head.start_res;
  assign length    = head.length;
  assign value     = head.value;
  assign op_first  = head.op_first;
  assign op_second = head.op_second;
  assign last      = head.last;

endmodule
